### design/vfvm_pkg.sv
// Shared types, constants and address helpers for the voxel face visibility block.
package vfvm_pkg;

  // Grid geometry and cell layout
  localparam int GRID_SIDE  = 16;
  localparam int KIND_BITS  = 8;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = KIND_BITS + 2;
  localparam int SOLID_POS  = KIND_BITS;
  localparam int CLEAR_POS  = KIND_BITS + 1;

  // Fixed port widths
  localparam int POS_W      = 4;
  localparam int KIND_IN_W  = 8;
  localparam int MASK_W     = 6;
  localparam int FACE_W     = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_ZERO
  } op_e;

  typedef enum logic [FACE_W-1:0] {
    FACE_BACK   = 3'd0,
    FACE_FRONT  = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_TOP    = 3'd4,
    FACE_BOTTOM = 3'd5
  } face_e;

  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [CELL_W-1:0] cell_bits;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic              in_grid;
    logic [ADDR_W-1:0] addr;
  } nb_t;

  function automatic logic coord_ok(logic [POS_W-1:0] c);
    return int'(c) < GRID_SIDE;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [POS_W-1:0] x,
                                                 logic [POS_W-1:0] y,
                                                 logic [POS_W-1:0] z);
    logic [ADDR_W-1:0] ax;
    logic [ADDR_W-1:0] ay;
    ax = ADDR_W'(x) * ADDR_W'(GRID_SIDE * GRID_SIDE);
    ay = ADDR_W'(y) * ADDR_W'(GRID_SIDE);
    return ax + ay + ADDR_W'(z);
  endfunction

  // Locate the neighbor across one face and tell whether it is inside the grid
  function automatic nb_t neighbor(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                   logic [POS_W-1:0] z, logic [FACE_W-1:0] f);
    nb_t              r;
    logic [POS_W-1:0] nx;
    logic [POS_W-1:0] ny;
    logic [POS_W-1:0] nz;
    nx = x;
    ny = y;
    nz = z;
    r.in_grid = 1'b0;
    case (f)
      FACE_BACK: begin
        r.in_grid = (z != '0);
        nz = z - POS_W'(1);
      end
      FACE_FRONT: begin
        r.in_grid = (int'(z) + 1 < GRID_SIDE);
        nz = z + POS_W'(1);
      end
      FACE_LEFT: begin
        r.in_grid = (x != '0);
        nx = x - POS_W'(1);
      end
      FACE_RIGHT: begin
        r.in_grid = (int'(x) + 1 < GRID_SIDE);
        nx = x + POS_W'(1);
      end
      FACE_TOP: begin
        r.in_grid = (int'(y) + 1 < GRID_SIDE);
        ny = y + POS_W'(1);
      end
      FACE_BOTTOM: begin
        r.in_grid = (y != '0);
        ny = y - POS_W'(1);
      end
      default: r.in_grid = 1'b0;
    endcase
    r.addr = cell_addr(nx, ny, nz);
    return r;
  endfunction

endpackage

### design/vfvm_queue.sv
// Two-entry command queue that decouples the front from the back.
module vfvm_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vfvm_pkg::cmd_t         wdata_i,
  input  logic                   pop_i,
  output vfvm_pkg::cmd_t         rdata_o,
  output vfvm_pkg::queue_status_t status_o
);

  vfvm_pkg::cmd_t                    entries_q [vfvm_pkg::QUEUE_DEPTH];
  logic [vfvm_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [vfvm_pkg::QCNT_W-1:0]       count_q;
  logic                              do_push, do_pop;

  assign status_o.full  = (int'(count_q) == vfvm_pkg::QUEUE_DEPTH);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = entries_q[rd_ptr_q];

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == vfvm_pkg::QUEUE_DEPTH - 1) ? '0
                    : wr_ptr_q + vfvm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == vfvm_pkg::QUEUE_DEPTH - 1) ? '0
                    : rd_ptr_q + vfvm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + vfvm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - vfvm_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### design/vfvm_front.sv
// Front end: accepts input transactions, range-checks them and classifies them.
module vfvm_front (
  input  logic                             push,
  output logic                             full,
  input  logic                             action_i,
  input  logic [vfvm_pkg::POS_W-1:0]       pos_x_i,
  input  logic [vfvm_pkg::POS_W-1:0]       pos_y_i,
  input  logic [vfvm_pkg::POS_W-1:0]       pos_z_i,
  input  logic [vfvm_pkg::KIND_IN_W-1:0]   cell_kind_i,
  input  logic                             cell_solid_i,
  input  logic                             cell_clear_i,
  input  vfvm_pkg::queue_status_t          q_status_i,
  output logic                             q_push_o,
  output vfvm_pkg::cmd_t                   q_cmd_o
);

  logic                                  pos_ok;
  logic [vfvm_pkg::KIND_BITS-1:0]        kind;

  assign full   = q_status_i.full;
  assign pos_ok = vfvm_pkg::coord_ok(pos_x_i) && vfvm_pkg::coord_ok(pos_y_i)
                  && vfvm_pkg::coord_ok(pos_z_i);
  assign kind   = vfvm_pkg::KIND_BITS'(cell_kind_i);

  // Classify: in-grid write, in-grid query, or query answered with zero
  always_comb begin
    q_cmd_o.x         = pos_x_i;
    q_cmd_o.y         = pos_y_i;
    q_cmd_o.z         = pos_z_i;
    q_cmd_o.cell_bits = {cell_clear_i, cell_solid_i, kind};
    if (!action_i) begin
      q_cmd_o.op = vfvm_pkg::OP_WRITE;
    end else if (pos_ok) begin
      q_cmd_o.op = vfvm_pkg::OP_QUERY;
    end else begin
      q_cmd_o.op = vfvm_pkg::OP_ZERO;
    end
  end

  // Drop writes outside the grid; forward everything else
  assign q_push_o = push && !q_status_i.full && (action_i || pos_ok);

endmodule

### design/vfvm_back.sv
// Back end: voxel memory, neighbor read sequencer and result register.
module vfvm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vfvm_pkg::queue_status_t       q_status_i,
  input  vfvm_pkg::cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [vfvm_pkg::MASK_W-1:0]   vis_mask_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  localparam logic [2:0] STEP_LAST = 3'd7;

  state_e                             state_q, state_d;
  logic [2:0]                         step_q, step_d;
  logic [vfvm_pkg::POS_W-1:0]         cx_q, cy_q, cz_q;
  logic [vfvm_pkg::KIND_BITS-1:0]     self_kind_q, self_kind_d;
  logic [vfvm_pkg::MASK_W-1:0]        mask_q, mask_d;
  logic                               pend_q, pend_d;
  logic [vfvm_pkg::MASK_W-1:0]        out_mask_q;
  logic                               out_valid_q;

  logic [vfvm_pkg::CELL_W-1:0]        mem_q [vfvm_pkg::CELL_COUNT];
  logic [vfvm_pkg::CELL_W-1:0]        rdata_q;
  logic                               mem_we, mem_re;
  logic [vfvm_pkg::ADDR_W-1:0]        mem_addr;

  logic [2:0]                         issue_face, eval_face;
  vfvm_pkg::nb_t                      nb;
  logic                               nb_show;
  logic                               out_free;

  assign empty       = !out_valid_q;
  assign vis_mask_o  = out_mask_q;
  assign out_free    = !out_valid_q || pop;
  assign q_pop_o     = (state_q == ST_IDLE) && !q_status_i.empty;

  // Single-port voxel memory with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= q_cmd_i.cell_bits;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign issue_face = step_q - 3'd1;
  assign eval_face  = step_q - 3'd2;
  assign nb         = vfvm_pkg::neighbor(cx_q, cy_q, cz_q, issue_face);
  assign nb_show    = !rdata_q[vfvm_pkg::SOLID_POS]
                      || (rdata_q[vfvm_pkg::CLEAR_POS]
                          && (rdata_q[vfvm_pkg::KIND_BITS-1:0] != self_kind_q));

  // Sequence one read per cycle: own cell first, then the six neighbors
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    self_kind_d = self_kind_q;
    mask_d      = mask_q;
    pend_d      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = vfvm_pkg::cell_addr(cx_q, cy_q, cz_q);
    case (state_q)
      ST_IDLE: begin
        mem_addr = vfvm_pkg::cell_addr(q_cmd_i.x, q_cmd_i.y, q_cmd_i.z);
        if (!q_status_i.empty) begin
          case (q_cmd_i.op)
            vfvm_pkg::OP_WRITE: mem_we = 1'b1;
            vfvm_pkg::OP_QUERY: begin
              state_d = ST_READ;
              step_d  = 3'd0;
              mask_d  = '0;
            end
            default: begin
              state_d = ST_DONE;
              mask_d  = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        // Issue the read for this step
        if (step_q == 3'd0) begin
          mem_re = 1'b1;
        end else if (step_q != STEP_LAST) begin
          mem_addr = nb.addr;
          if (nb.in_grid) begin
            mem_re = 1'b1;
          end else begin
            mask_d[issue_face] = 1'b1;
          end
        end
        pend_d = mem_re;
        // Evaluate the read issued one step earlier
        if (pend_q) begin
          if (step_q == 3'd1) begin
            self_kind_d = rdata_q[vfvm_pkg::KIND_BITS-1:0];
          end else if (nb_show) begin
            mask_d[eval_face] = 1'b1;
          end
        end
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold query state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      self_kind_q <= '0;
      mask_q      <= '0;
      out_mask_q  <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pend_q      <= pend_d;
      self_kind_q <= self_kind_d;
      mask_q      <= mask_d;
      if (q_pop_o) begin
        cx_q <= q_cmd_i.x;
        cy_q <= q_cmd_i.y;
        cz_q <= q_cmd_i.z;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_mask_q  <= mask_q;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### design/voxel_face_visibility_mask.sv
// Top level of the voxel face visibility block: front, command queue and back.
//
// The block stores a cubic grid of voxel cells (type code, solid flag,
// transparent flag) in one single-port memory and answers face visibility
// queries. A write transaction goes to the memory as the back end takes it
// and produces no result; a write outside the grid is dropped at the input.
// A query walks the single memory port, with its registered read data, one
// read per cycle: its own cell, then the six neighbors (reads for neighbors
// outside the grid are skipped); the back end takes no new command until
// the result is registered. Queries outside the grid return a zero mask
// without reading the memory. A two-entry command queue lets input
// transactions land while a query is being worked, and a one-entry result
// register holds the answer until it is popped. The memory has no reset:
// every cell must be written before a query touches it.
module voxel_face_visibility_mask (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [vfvm_pkg::POS_W-1:0]      pos_x_i,
  input  logic [vfvm_pkg::POS_W-1:0]      pos_y_i,
  input  logic [vfvm_pkg::POS_W-1:0]      pos_z_i,
  input  logic [vfvm_pkg::KIND_IN_W-1:0]  cell_kind_i,
  input  logic                            cell_solid_i,
  input  logic                            cell_clear_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [vfvm_pkg::MASK_W-1:0]     vis_mask_o
);

  vfvm_pkg::queue_status_t q_status;
  vfvm_pkg::cmd_t          q_wcmd, q_rcmd;
  logic                    q_push, q_pop;

  vfvm_front u_front (
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cell_kind_i  (cell_kind_i),
    .cell_solid_i (cell_solid_i),
    .cell_clear_i (cell_clear_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_cmd_o      (q_wcmd)
  );

  vfvm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wdata_i  (q_wcmd),
    .pop_i    (q_pop),
    .rdata_o  (q_rcmd),
    .status_o (q_status)
  );

  vfvm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .vis_mask_o  (vis_mask_o)
  );

endmodule

### design/vfvm_checker.sv
// Port-level checker for the voxel face visibility block, bound to the top level.
module vfvm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input logic                            full,
  input logic                            action_i,
  input logic                            empty,
  input logic                            pop,
  input logic [vfvm_pkg::MASK_W-1:0]     vis_mask_o
);

  logic [3:0] open_q;
  logic       q_in, q_out;

  assign q_in  = push && !full && action_i;
  assign q_out = pop && !empty;

  // Track queries accepted but not yet popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (q_in && !q_out) begin
      open_q <= open_q + 4'd1;
    end else if (q_out && !q_in) begin
      open_q <= open_q - 4'd1;
    end
  end

  // No result is shown during reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // A shown result holds until it is popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(vis_mask_o)))
    else $error("result changed while waiting");

  // Every result belongs to an accepted query
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (open_q != 4'd0))
    else $error("result without a pending query");

  // Popping the last pending query leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_out && open_q == 4'd1 && !q_in) |=> empty)
    else $error("extra result after the last query");

endmodule

bind voxel_face_visibility_mask vfvm_checker u_vfvm_checker (.*);
